// ===== sv/lrv_pkg.sv =====
`timescale 1ns / 1ps
// lrv_pkg: constants, header and result types of the log record validator.
// No dependencies; imported by every other file of the block.

package lrv_pkg;

  // Offsets saturate at the top of this range
  localparam int unsigned OffsetWidth    = 48;
  localparam int unsigned OutOffsetWidth = 48;
  localparam int unsigned ByteIdxWidth   = 32;

  localparam logic [31:0] RecMagic  = 32'h3144_534c;
  localparam logic [63:0] FnvBasis  = 64'hcbf2_9ce4_8422_2325;
  localparam logic [31:0] HdrLen    = 32'd40;
  localparam logic [7:0]  OpPut     = 8'd1;
  localparam logic [7:0]  OpDelete  = 8'd2;

  // Result queue
  localparam int unsigned ResDepth    = 4;
  localparam int unsigned ResPtrWidth = $clog2(ResDepth);
  localparam int unsigned ResCntWidth = $clog2(ResDepth + 1);

  typedef logic [OffsetWidth-1:0] offset_t;

  localparam offset_t OffMax = '1;

  typedef enum logic [1:0] {
    KindValid   = 2'd0,
    KindInvalid = 2'd1,
    KindEnd     = 2'd2
  } kind_e;

  // Header fields as captured from the byte stream
  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] length;
    logic [15:0] tenant;
    logic [15:0] key;
    logic [31:0] value;
    logic [7:0]  op;
    logic [63:0] key_digest;
    logic [63:0] check;
  } hdr_t;

  typedef struct packed {
    kind_e       kind;
    offset_t     offset;
    logic [31:0] length;
    logic        del;
    logic [63:0] key_digest;
    offset_t     good_len;
    logic        last;
  } res_t;

  // Queue write strobes; second only together with the first
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// ===== sv/lrv_intf.sv =====
`timescale 1ns / 1ps
// lrv_in_if / lrv_out_if: valid/ready channels of the log record validator.
// Depends on lrv_pkg for field widths.

interface lrv_in_if;
  import lrv_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface lrv_out_if;
  import lrv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [OutOffsetWidth-1:0] record_offset;
  logic [31:0]               record_length;
  logic                      is_delete;
  logic [63:0]               record_key_hash;
  logic [OutOffsetWidth-1:0] valid_prefix;
  logic                      last_result;

  modport source (output valid, result_kind, record_offset, record_length, is_delete,
                  record_key_hash, valid_prefix, last_result, input ready);
  modport sink   (input valid, result_kind, record_offset, record_length, is_delete,
                  record_key_hash, valid_prefix, last_result, output ready);
endinterface

// ===== sv/lrv_hash.sv =====
`timescale 1ns / 1ps
// lrv_hash: one FNV-1a 64 multiply per byte, header folds scheduled over bytes 0..39.
// Depends on lrv_pkg.

module lrv_hash (
  input  logic [63:0]                    hash_i,
  input  logic [lrv_pkg::ByteIdxWidth-1:0] byte_idx_i,
  input  logic [7:0]                     data_i,
  input  lrv_pkg::hdr_t                  hdr_i,
  output logic [63:0]                    hash_o
);
  import lrv_pkg::*;

  // prime = 2^40 + 0x1b3; prime^2 mod 2^64 = 0x366 * 2^40 + 0x2e329
  localparam logic [17:0] PrimeLo  = 18'h001b3;
  localparam logic [9:0]  PrimeHi  = 10'h001;
  localparam logic [17:0] Prime2Lo = 18'h2e329;
  localparam logic [9:0]  Prime2Hi = 10'h366;

  logic [7:0]  x;
  logic        dbl;
  logic [63:0] v;
  logic [63:0] prod_lo;
  logic [23:0] prod_hi;

  // Header stream: each field as 8 bytes, zero bytes paired so that a
  // data byte plus a zero, or two zeros, is one multiply by prime^2.
  always_comb begin
    x   = '0;
    dbl = 1'b0;
    if (byte_idx_i >= HdrLen) begin
      x = data_i;
    end else begin
      unique case (byte_idx_i[5:0])
        6'd0, 6'd1, 6'd2: x = data_i;
        6'd3: begin
          x   = data_i;
          dbl = 1'b1;
        end
        6'd6:  x = hdr_i.length[7:0];
        6'd7:  x = hdr_i.length[15:8];
        6'd8:  x = hdr_i.length[23:16];
        6'd9: begin
          x   = hdr_i.length[31:24];
          dbl = 1'b1;
        end
        6'd12: x = hdr_i.tenant[7:0];
        6'd13: begin
          x   = hdr_i.tenant[15:8];
          dbl = 1'b1;
        end
        6'd17: x = hdr_i.key[7:0];
        6'd18: begin
          x   = hdr_i.key[15:8];
          dbl = 1'b1;
        end
        6'd22: x = hdr_i.value[7:0];
        6'd23: x = hdr_i.value[15:8];
        6'd24: x = hdr_i.value[23:16];
        6'd25: begin
          x   = hdr_i.value[31:24];
          dbl = 1'b1;
        end
        6'd28: begin
          x   = hdr_i.op;
          dbl = 1'b1;
        end
        6'd4, 6'd10, 6'd14, 6'd15, 6'd19, 6'd20, 6'd26, 6'd29, 6'd30, 6'd31: dbl = 1'b1;
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39: begin
          x = hdr_i.key_digest[{byte_idx_i[2:0], 3'b000} +: 8];
        end
        default: x = '0;
      endcase
    end
  end

  assign v       = hash_i ^ {56'd0, x};
  assign prod_lo = v * 64'(dbl ? Prime2Lo : PrimeLo);
  assign prod_hi = v[23:0] * 24'(dbl ? Prime2Hi : PrimeHi);
  assign hash_o  = prod_lo + {prod_hi, 40'd0};

endmodule

// ===== sv/lrv_core.sv =====
`timescale 1ns / 1ps
// lrv_core: record state, header capture, checks and result generation per byte.
// Depends on lrv_pkg and lrv_hash.

module lrv_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_i,
  input  logic          first_i,
  input  logic          last_i,
  output lrv_pkg::push_t push_o,
  output lrv_pkg::res_t  res0_o,
  output lrv_pkg::res_t  res1_o
);
  import lrv_pkg::*;

  localparam logic [ByteIdxWidth-1:0] LastHdrIdx = ByteIdxWidth'(HdrLen - 32'd1);

  offset_t                 log_off_q, log_off_d, log_off_e;
  offset_t                 rec_start_q, rec_start_d, rec_start_e;
  logic [ByteIdxWidth-1:0] bir_q, bir_d, bir_e;
  logic                    stopped_q, stopped_d, stopped_e;
  logic [63:0]             hash_q, hash_d, hash_in, hash_fold;
  hdr_t                    hdr_q, hdr_d;

  logic                    bad, done;
  logic [32:0]             body_len;
  offset_t                 pos_inc;
  logic [OffsetWidth:0]    vb_sum;
  offset_t                 vb;
  logic                    rec_push;
  res_t                    rec_res, end_res;

  // A new log starts from the reset state
  assign log_off_e   = first_i ? '0 : log_off_q;
  assign rec_start_e = first_i ? '0 : rec_start_q;
  assign bir_e       = first_i ? '0 : bir_q;
  assign stopped_e   = first_i ? 1'b0 : stopped_q;
  assign hash_in     = (bir_e == '0) ? FnvBasis : hash_q;

  lrv_hash u_hash (
    .hash_i     (hash_in),
    .byte_idx_i (bir_e),
    .data_i     (data_i),
    .hdr_i      (hdr_q),
    .hash_o     (hash_fold)
  );

  // Lane capture; every lane is rewritten before it is read in a record
  always_comb begin
    hdr_d = hdr_q;
    priority if (bir_e < 32'd4) begin
      hdr_d.magic[{bir_e[1:0], 3'b000} +: 8] = data_i;
    end else if (bir_e < 32'd8) begin
      hdr_d.length[{bir_e[1:0], 3'b000} +: 8] = data_i;
    end else if (bir_e < 32'd10) begin
      hdr_d.tenant[{bir_e[0], 3'b000} +: 8] = data_i;
    end else if (bir_e < 32'd12) begin
      hdr_d.key[{bir_e[0], 3'b000} +: 8] = data_i;
    end else if (bir_e < 32'd16) begin
      hdr_d.value[{bir_e[1:0], 3'b000} +: 8] = data_i;
    end else if (bir_e == 32'd16) begin
      hdr_d.op = data_i;
    end else if (bir_e >= 32'd24 && bir_e < 32'd32) begin
      hdr_d.key_digest[{bir_e[2:0], 3'b000} +: 8] = data_i;
    end else if (bir_e >= 32'd32 && bir_e < HdrLen) begin
      hdr_d.check[{bir_e[2:0], 3'b000} +: 8] = data_i;
    end else begin
      hdr_d = hdr_q;
    end
  end

  assign body_len = {17'd0, hdr_d.tenant} + {17'd0, hdr_d.key} + {1'b0, hdr_d.value};

  always_comb begin
    bad = 1'b0;
    if (bir_e == 32'd3 && hdr_d.magic != RecMagic) bad = 1'b1;
    if (bir_e == 32'd15) begin
      if (hdr_d.length < HdrLen || {1'b0, hdr_d.length - HdrLen} != body_len) bad = 1'b1;
    end
    if (bir_e == 32'd16) begin
      if (hdr_d.op != OpPut && hdr_d.op != OpDelete) bad = 1'b1;
      else if (hdr_d.op == OpDelete && hdr_d.value != '0) bad = 1'b1;
    end
    done = !bad && bir_e >= LastHdrIdx && bir_e == hdr_d.length - 32'd1;
    if (done && hash_fold != hdr_d.check) bad = 1'b1;
  end

  assign pos_inc = (log_off_e == OffMax) ? OffMax : log_off_e + offset_t'(1);
  assign vb_sum  = {1'b0, rec_start_e} + (OffsetWidth + 1)'(hdr_d.length);
  assign vb      = (vb_sum >= {1'b0, OffMax}) ? OffMax : vb_sum[OffsetWidth-1:0];

  always_comb begin
    stopped_d   = stopped_e;
    rec_start_d = rec_start_e;
    bir_d       = bir_e;
    hash_d      = hash_q;
    rec_push    = 1'b0;
    rec_res     = '{kind: KindInvalid, offset: rec_start_e, length: '0, del: 1'b0,
                    key_digest: '0, good_len: rec_start_e, last: 1'b0};
    if (!stopped_e) begin
      hash_d = hash_fold;
      if (bad) begin
        rec_push  = 1'b1;
        stopped_d = 1'b1;
      end else if (done) begin
        rec_push    = 1'b1;
        rec_res     = '{kind: KindValid, offset: rec_start_e, length: hdr_d.length,
                        del: (hdr_d.op == OpDelete), key_digest: hdr_d.key_digest,
                        good_len: vb, last: 1'b0};
        rec_start_d = pos_inc;
        bir_d       = '0;
      end else begin
        bir_d = bir_e + 32'd1;
      end
    end
    // Log ends inside a record: that record fails
    if (last_i && !stopped_d && bir_d != '0) begin
      rec_push  = 1'b1;
      stopped_d = 1'b1;
      rec_res   = '{kind: KindInvalid, offset: rec_start_d, length: '0, del: 1'b0,
                    key_digest: '0, good_len: rec_start_d, last: 1'b0};
    end
    end_res = '{kind: KindEnd, offset: '0, length: '0, del: 1'b0, key_digest: '0,
                good_len: rec_start_d, last: 1'b1};
  end

  assign log_off_d = pos_inc;

  always_comb begin
    push_o.push0 = step_i && (rec_push || last_i);
    push_o.push1 = step_i && rec_push && last_i;
    res0_o       = rec_push ? rec_res : end_res;
    res0_o.last  = !(rec_push && last_i);
    res1_o       = end_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_off_q   <= '0;
      rec_start_q <= '0;
      bir_q       <= '0;
      stopped_q   <= 1'b0;
      hash_q      <= FnvBasis;
    end else if (step_i) begin
      log_off_q   <= log_off_d;
      rec_start_q <= rec_start_d;
      bir_q       <= bir_d;
      stopped_q   <= stopped_d;
      hash_q      <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !stopped_e) begin
      hdr_q <= hdr_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_after_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push0 && res0_o.kind == KindInvalid) |=> stopped_q)
    else $error("invalid record did not stop the log");

  a_restart_after_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push0 && res0_o.kind == KindValid) |=> (bir_q == '0))
    else $error("record progress not cleared after a valid record");
`endif

endmodule

// ===== sv/lrv_res_fifo.sv =====
`timescale 1ns / 1ps
// lrv_res_fifo: small result queue, up to two writes and one read per cycle.
// Depends on lrv_pkg.

module lrv_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lrv_pkg::push_t push_i,
  input  lrv_pkg::res_t  data0_i,
  input  lrv_pkg::res_t  data1_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lrv_pkg::res_t  out_data_o
);
  import lrv_pkg::*;

  res_t                   mem_q [ResDepth];
  logic [ResPtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ResCntWidth-1:0] count_q, count_d;
  logic                   pop;

  // Room for two results, judged on registered state only
  assign room_o      = count_q <= ResCntWidth'(ResDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrWidth'(push_i.push0) + ResPtrWidth'(push_i.push1);
    rd_ptr_d = rd_ptr_q + ResPtrWidth'(pop);
    count_d  = count_q + ResCntWidth'(push_i.push0) + ResCntWidth'(push_i.push1)
               - ResCntWidth'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wr_ptr_q] <= data0_i;
    if (push_i.push1) mem_q[wr_ptr_q + ResPtrWidth'(1)] <= data1_i;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push0 |-> room_o)
    else $error("result pushed without room");

  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed alone");
`endif

endmodule

// ===== sv/log_record_validator.sv =====
`timescale 1ns / 1ps
// log_record_validator: top level, input register, record core and result queue.
// Depends on lrv_pkg, lrv_intf, lrv_core, lrv_hash and lrv_res_fifo.
//
// Usage
//  - item_i carries one log byte per transaction, with first_byte marking the
//    start of a new log and last_byte its final byte. result_o carries the
//    reports: valid record, invalid record (the log then stops) and end of log.
//  - A transaction completes at a rising edge with valid and ready both high.
//  - Result path: a byte that was taken steps from the input register
//    through the core into the result queue, whose head is offered on
//    result_o; the step waits while the queue lacks room for two results.
//  - Throughput: one byte per cycle while the queue has room. The hash does
//    one FNV-1a fold per byte; header zero bytes are paired into
//    prime-squared multiplies so the header hash is complete by byte 39.
//    A byte ending a log with a record or truncation report queues both.
//  - item_i.ready depends only on registers: it drops while the input
//    register is full and the four-entry result queue holds more than two.
//  - When result_o is stalled the queue fills, then bytes back up into the
//    input register, then ready falls; nothing is dropped.
//  - Reset: the log offset, record progress and stop flag clear and the
//    queue empties, so the first byte after reset starts a log even without
//    first_byte.

module log_record_validator (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrv_in_if.sink    item_i,
  lrv_out_if.source result_o
);
  import lrv_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [7:0] data_q;
  logic       first_q;
  logic       last_q;

  logic       step;
  logic       room;
  push_t      push;
  res_t       res0, res1, head;
  logic       head_valid;

  // A byte moves into the core whenever the queue can take two results
  assign step         = in_valid_q && room;
  assign item_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      data_q  <= item_i.data_byte;
      first_q <= item_i.first_byte;
      last_q  <= item_i.last_byte;
    end
  end

  lrv_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .data_i  (data_q),
    .first_i (first_q),
    .last_i  (last_q),
    .push_o  (push),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  lrv_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data0_i     (res0),
    .data1_i     (res1),
    .room_o      (room),
    .out_valid_o (head_valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (head)
  );

  // Result channel straight from the queue head
  assign result_o.valid           = head_valid;
  assign result_o.result_kind     = head.kind;
  assign result_o.record_offset   = OutOffsetWidth'(head.offset);
  assign result_o.record_length   = head.length;
  assign result_o.is_delete       = head.del;
  assign result_o.record_key_hash = head.key_digest;
  assign result_o.valid_prefix    = OutOffsetWidth'(head.good_len);
  assign result_o.last_result     = head.last;

endmodule

// ===== tb/lrv_check_pkg.sv =====
`timescale 1ns / 1ps
// lrv_check_pkg: report scoreboard for the log record validator testbench,
// with its own record-walking predictor and FNV-1a helpers. Depends on lrv_pkg.

package lrv_check_pkg;
  import lrv_pkg::*;

  localparam bit [63:0] FnvPrime = 64'h0000_0100_0000_01b3;

  class record_scoreboard;
    offset_t     log_pos;
    offset_t     rec_start;
    bit [31:0]   rec_byte;
    bit [31:0]   magic;
    bit [31:0]   total_len;
    bit [15:0]   tenant_len;
    bit [15:0]   key_len;
    bit [31:0]   value_len;
    bit [7:0]    op;
    bit [63:0]   key_digest;
    bit [63:0]   check;
    bit [63:0]   hash;
    bit          halted;
    res_t        pending_reports[$];
    int unsigned errors;

    function new();
      restart_log();
      errors = 0;
    endfunction

    static function bit [63:0] fold_byte(bit [63:0] h, bit [7:0] d);
      return (h ^ {56'd0, d}) * FnvPrime;
    endfunction

    // one header field, fed as 8 zero-extended little-endian bytes
    static function bit [63:0] fold_word(bit [63:0] h, bit [63:0] x);
      int i;
      for (i = 0; i < 8; i++) begin
        h = fold_byte(h, x[8*i +: 8]);
      end
      return h;
    endfunction

    static function bit [63:0] header_hash(bit [31:0] m, bit [31:0] l, bit [15:0] tl,
                                           bit [15:0] kl, bit [31:0] vl, bit [7:0] o,
                                           bit [63:0] kh);
      bit [63:0] h;
      h = FnvBasis;
      h = fold_word(h, {32'd0, m});
      h = fold_word(h, {32'd0, l});
      h = fold_word(h, {48'd0, tl});
      h = fold_word(h, {48'd0, kl});
      h = fold_word(h, {32'd0, vl});
      h = fold_word(h, {56'd0, o});
      h = fold_word(h, kh);
      return h;
    endfunction

    static function offset_t sat_add(offset_t a, offset_t b);
      if (a == OffMax || b >= OffMax - a) return OffMax;
      return a + b;
    endfunction

    function void clear_header();
      magic      = '0;
      total_len  = '0;
      tenant_len = '0;
      key_len    = '0;
      value_len  = '0;
      op         = '0;
      key_digest = '0;
      check      = '0;
    endfunction

    function void restart_log();
      log_pos   = '0;
      rec_start = '0;
      rec_byte  = '0;
      clear_header();
      hash   = FnvBasis;
      halted = 1'b0;
    endfunction

    function void push_report(kind_e kind, offset_t offs, bit [31:0] len, bit del,
                              bit [63:0] kh, offset_t vb);
      res_t r;
      r.kind       = kind;
      r.offset     = offs;
      r.length     = len;
      r.del        = del;
      r.key_digest = kh;
      r.good_len   = vb;
      r.last       = 1'b0;
      pending_reports.push_back(r);
    endfunction

    // Walks one accepted byte through the record format and queues its reports
    function void take_byte(bit [7:0] d, bit first, bit fin);
      offset_t     here;
      bit [31:0]   b;
      bit [63:0]   body_len;
      bit          bad;
      bit          done;
      int unsigned n0;
      n0 = pending_reports.size();
      if (first) restart_log();
      here = log_pos;
      if (!halted) begin
        b    = rec_byte;
        bad  = 1'b0;
        done = 1'b0;
        if (b == 0) begin
          clear_header();
          hash = FnvBasis;
        end
        if (b < 4)                  magic[8*b +: 8]             = d;
        else if (b < 8)             total_len[8*(b-4) +: 8]     = d;
        else if (b < 10)            tenant_len[8*(b-8) +: 8]    = d;
        else if (b < 12)            key_len[8*(b-10) +: 8]      = d;
        else if (b < 16)            value_len[8*(b-12) +: 8]    = d;
        else if (b == 16)           op                          = d;
        else if (b >= 24 && b < 32) key_digest[8*(b-24) +: 8]   = d;
        else if (b >= 32 && b < 40) check[8*(b-32) +: 8]        = d;
        else if (b >= 40)           hash                        = fold_byte(hash, d);

        // header part of the check is complete once the key hash is in
        if (b == 31)
          hash = header_hash(magic, total_len, tenant_len, key_len, value_len, op,
                             key_digest);

        if (b == 3 && magic != RecMagic) bad = 1'b1;
        if (b == 15) begin
          body_len = {48'd0, tenant_len} + {48'd0, key_len} + {32'd0, value_len};
          if (total_len < HdrLen || {32'd0, total_len - HdrLen} != body_len) bad = 1'b1;
        end
        if (b == 16) begin
          if (op != OpPut && op != OpDelete) bad = 1'b1;
          else if (op == OpDelete && value_len != 0) bad = 1'b1;
        end
        if (!bad && b >= HdrLen - 1 && b == total_len - 1) begin
          done = 1'b1;
          if (hash != check) bad = 1'b1;
        end

        if (bad) begin
          push_report(KindInvalid, rec_start, '0, 1'b0, '0, rec_start);
          halted = 1'b1;
        end else if (done) begin
          push_report(KindValid, rec_start, total_len, op == OpDelete, key_digest,
                      sat_add(rec_start, offset_t'(total_len)));
          rec_start = sat_add(here, offset_t'(1));
          rec_byte  = '0;
          hash      = FnvBasis;
        end else begin
          rec_byte = b + 1;
        end
      end

      if (fin) begin
        // file ends inside a record that had not failed yet
        if (!halted && rec_byte != 0) begin
          push_report(KindInvalid, rec_start, '0, 1'b0, '0, rec_start);
          halted = 1'b1;
        end
        push_report(KindEnd, '0, '0, 1'b0, '0, rec_start);
      end

      if (pending_reports.size() > n0)
        pending_reports[pending_reports.size()-1].last = 1'b1;
      log_pos = sat_add(here, offset_t'(1));
    endfunction

    function int unsigned outstanding();
      return pending_reports.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("unexpected result, kind %0d offset %0d", got.kind, got.offset));
        return;
      end
      want = pending_reports.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.offset !== want.offset)
        report($sformatf("record_offset %0d, expected %0d", got.offset, want.offset));
      if (got.length !== want.length)
        report($sformatf("record_length %0d, expected %0d", got.length, want.length));
      if (got.del !== want.del)
        report($sformatf("is_delete %0b, expected %0b", got.del, want.del));
      if (got.key_digest !== want.key_digest)
        report($sformatf("key hash %h, expected %h", got.key_digest, want.key_digest));
      if (got.good_len !== want.good_len)
        report($sformatf("valid_prefix %0d, expected %0d", got.good_len, want.good_len));
      if (got.last !== want.last)
        report($sformatf("last_result %0b, expected %0b", got.last, want.last));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for log_record_validator. Builds logs of good
// and damaged records, streams them byte by byte with random idling on both
// sides and scores every report. Depends on lrv_pkg, lrv_intf, lrv_check_pkg.

module tb_top;
  import lrv_pkg::*;
  import lrv_check_pkg::*;

  localparam int unsigned IdleLimit   = 2000; // cycles with no transaction at all
  localparam int unsigned DrainCycles = 8;    // covers the result path, with margin
  localparam int unsigned MinBytes    = 1700;
  localparam int unsigned MinRecords  = 12;

  // ways of spoiling a record
  typedef enum int {
    DefNone,
    DefMagic,
    DefShort,     // total length below the header size
    DefLength,    // total length disagrees with the body lengths
    DefOp,
    DefDelValue,  // delete that carries a value
    DefCheck
  } defect_e;

  typedef struct {
    bit [7:0] data;
    bit       first;
    bit       fin;
  } log_byte_t;

  logic clk_i;
  logic rst_ni;

  lrv_in_if  in_if ();
  lrv_out_if out_if ();

  log_record_validator u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if)
  );

  record_scoreboard sb;
  log_byte_t        stream_q[$];   // the whole byte stream, built up front
  bit               open_first;    // next byte pushed opens a new log
  int unsigned      n_records;
  int unsigned      bytes_sent;
  int unsigned      results_taken;
  int unsigned      idle_cycles;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Log construction
  // ---------------------------------------------------------------------

  function automatic void push_byte(bit [7:0] d);
    log_byte_t e;
    e.data  = d;
    e.first = open_first;
    e.fin   = 1'b0;
    open_first = 1'b0;
    stream_q.push_back(e);
  endfunction

  function automatic void push_noise(int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void start_log();
    open_first = 1'b1;
  endfunction

  // last_byte goes on the most recent byte; a log needs at least one
  function automatic void end_log();
    if (stream_q.size() == 0 || open_first) push_noise(1);
    stream_q[stream_q.size()-1].fin = 1'b1;
  endfunction

  // Builds one record. A cut of zero or more stops it after that many bytes;
  // its check is then meaningless and left random.
  function automatic void push_record(defect_e defect, bit [15:0] t, bit [15:0] k,
                                      bit [31:0] v, bit [7:0] op, int cut);
    bit [31:0]       magic;
    bit [31:0]       len;
    bit [63:0]       khash;
    bit [63:0]       chk;
    bit [55:0]       pad;
    bit [319:0]      hdr;
    bit [7:0]        body[$];
    longint unsigned full;
    longint unsigned total;
    longint unsigned i;
    magic = RecMagic;
    khash = {$urandom, $urandom};
    pad   = 56'({$urandom, $urandom});
    case (defect)
      DefMagic: begin
        magic = $urandom;
        if (magic == RecMagic) magic = ~magic;
      end
      DefOp: begin
        while (op == OpPut || op == OpDelete) op = 8'($urandom_range(0, 255));
      end
      DefDelValue: begin
        op = OpDelete;
        if (v == 0) v = 1;
      end
      default: ;
    endcase
    full = 64'd40 + t + k + v;
    len  = full[31:0];
    if (defect == DefShort) len = $urandom_range(0, 39);
    if (defect == DefLength)
      len = len + (($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : ($urandom | 1));

    total = (cut >= 0 && cut < full) ? longint'(cut) : full;
    if (cut < 0) repeat (full - 40) body.push_back(8'($urandom_range(0, 255)));
    chk = record_scoreboard::header_hash(magic, len, t, k, v, op, khash);
    foreach (body[j]) chk = record_scoreboard::fold_byte(chk, body[j]);
    if (cut >= 0) chk = {$urandom, $urandom};
    if (defect == DefCheck) chk ^= 64'd1 << $urandom_range(0, 63);

    hdr = {chk, khash, pad, op, v, k, t, len, magic};
    for (i = 0; i < total; i++) begin
      if (i < 40) push_byte(hdr[8*i +: 8]);
      else if (cut >= 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(body[i-40]);
    end
    n_records++;
  endfunction

  // Mostly small bodies, now and then a few hundred bytes. Returns 1 when the
  // record was spoilt, so the caller stops adding good records after it.
  function automatic bit push_random_record(bit cut_it);
    bit [15:0] t;
    bit [15:0] k;
    bit [31:0] v;
    bit [7:0]  op;
    defect_e   defect;
    int        cut;
    if ($urandom_range(0, 19) == 0) begin
      t = 16'($urandom_range(0, 200));
      k = 16'($urandom_range(0, 200));
      v = $urandom_range(0, 300);
    end else begin
      t = 16'($urandom_range(0, 3));
      k = 16'($urandom_range(0, 8));
      v = $urandom_range(0, 12);
    end
    op = ($urandom_range(0, 2) == 0) ? OpDelete : OpPut;
    if (op == OpDelete) v = 0;
    defect = DefNone;
    if (!cut_it && $urandom_range(0, 99) >= 72) defect = defect_e'($urandom_range(1, 6));
    if (defect == DefOp) op = 8'($urandom_range(0, 255));
    cut = -1;
    if (cut_it) cut = $urandom_range(1, 39 + t + k + v);
    push_record(defect, t, k, v, op, cut);
    return defect != DefNone;
  endfunction

  function automatic void build_logs();
    int unsigned nrec;
    int unsigned tail;
    int unsigned j;
    int unsigned recs0;
    bit          broken;

    // Straight after reset, no first_byte: minimal put, put with body,
    // delete with key; the end lands on the last byte of a good record.
    push_record(DefNone, 0, 0, 0, OpPut, -1);
    push_record(DefNone, 2, 3, 4, OpPut, -1);
    push_record(DefNone, 0, 5, 0, OpDelete, -1);
    end_log();
    // bad magic, bytes ignored afterwards, end while stopped
    start_log();
    push_record(DefNone, 1, 1, 1, OpPut, -1);
    push_record(DefMagic, 0, 0, 0, OpPut, -1);
    push_noise(6);
    end_log();
    start_log();
    push_record(DefShort, 2, 0, 0, OpPut, -1);
    end_log();
    start_log();
    push_record(DefNone, 0, 0, 1, OpPut, -1);
    push_record(DefLength, 1, 2, 3, OpPut, -1);
    push_noise(3);
    end_log();
    // unknown op 0, log left stopped and never ended; next first_byte clears it
    start_log();
    push_record(DefOp, 0, 0, 0, 8'd0, -1);
    start_log();
    push_record(DefOp, 0, 0, 0, 8'hff, -1);
    end_log();
    start_log();
    push_record(DefDelValue, 0, 2, 3, OpDelete, -1);
    end_log();
    start_log();
    push_record(DefCheck, 3, 3, 3, OpPut, -1);
    end_log();
    // file ends mid-record: truncation report, then the end
    start_log();
    push_record(DefNone, 1, 0, 2, OpPut, -1);
    push_record(DefNone, 0, 4, 4, OpPut, 20);
    end_log();
    // a log of one byte
    start_log();
    end_log();
    // largest lengths; dropped mid-record by a new log
    start_log();
    push_record(DefNone, 16'hffff, 16'hffff, 32'hffff_ffff - 32'd40 - 32'h1_fffe, OpPut, 45);
    // bad magic judged on the final byte
    start_log();
    push_record(DefNone, 0, 0, 0, OpDelete, -1);
    push_record(DefMagic, 0, 0, 0, OpPut, 4);
    end_log();
    // good log, then more bytes without first_byte: same log carries on
    start_log();
    push_record(DefNone, 4, 0, 0, OpPut, -1);
    end_log();
    push_noise(3);
    end_log();
    start_log();
    push_record(DefNone, 0, 300, 0, OpDelete, -1);
    end_log();

    recs0 = n_records;
    while (stream_q.size() < MinBytes || n_records - recs0 < MinRecords) begin
      if ($urandom_range(0, 15) != 0) start_log();
      if ($urandom_range(0, 19) == 0) begin
        push_noise($urandom_range(1, 50));
      end else begin
        nrec   = $urandom_range(0, 5);
        broken = 1'b0;
        for (j = 0; j < nrec && !broken; j++) broken = push_random_record(1'b0);
        if (broken && $urandom_range(0, 1) != 0) push_noise($urandom_range(1, 8));
      end
      tail = $urandom_range(0, 9);
      if (tail == 6 || tail == 7) void'(push_random_record(1'b1));
      if (tail == 8) push_noise($urandom_range(1, 6));
      if (tail != 7 && tail != 9) end_log();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // mostly short pauses, a few long ones; none during a calm stretch
  function automatic int unsigned pause_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic drive_bytes();
    log_byte_t   e;
    int unsigned gap;
    while (stream_q.size() != 0) begin
      e   = stream_q.pop_front();
      gap = pause_len((bytes_sent % 500) >= 380);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid      <= 1'b1;
      in_if.data_byte  <= e.data;
      in_if.first_byte <= e.first;
      in_if.last_byte  <= e.fin;
      @(posedge clk_i);
      while (in_if.ready !== 1'b1) @(posedge clk_i);
      sb.take_byte(e.data, e.first, e.fin);
      bytes_sent++;
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic take_results();
    res_t        got;
    int unsigned gap;
    forever begin
      gap = pause_len((results_taken % 40) >= 30);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (out_if.valid !== 1'b1) @(posedge clk_i);
      got.kind       = kind_e'(out_if.result_kind);
      got.offset     = out_if.record_offset;
      got.length     = out_if.record_length;
      got.del        = out_if.is_delete;
      got.key_digest = out_if.record_key_hash;
      got.good_len   = out_if.valid_prefix;
      got.last       = out_if.last_result;
      sb.check_result(got);
      results_taken++;
    end
  endtask

  // Watchdog: a hang on either side shows as a long run of cycles with no
  // transaction anywhere
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("** log_record_validator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb               = new();
    open_first       = 1'b0;
    n_records        = 0;
    bytes_sent       = 0;
    results_taken    = 0;
    idle_cycles      = 0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    build_logs();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      take_results();
    join_none
    drive_bytes();

    // every report in, then a drain wait to catch anything extra
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("** log_record_validator: PASSED **");
    end else begin
      $display("** log_record_validator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lrv_pkg.sv
sv/lrv_intf.sv
sv/lrv_hash.sv
sv/lrv_core.sv
sv/lrv_res_fifo.sv
sv/log_record_validator.sv
tb/lrv_check_pkg.sv
tb/tb_top.sv
